// ===== sv/rssd_pkg.sv =====
// rssd_pkg: types, constants and codes for the random sample smoothing dropout block.
// Used by every module of the block but rssd_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package rssd_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int DRAW_BITS   = 16;
  localparam int THR_W       = 16;
  localparam int WIN_W       = 6;
  localparam int POS_W       = 8;
  localparam int PEND_W      = 7;
  localparam int AGE_W       = 6;
  localparam int CNT_W       = 7;
  localparam int DIV_W       = WIN_W + 1;
  localparam int SUM_W       = SAMPLE_BITS + CNT_W;
  localparam int CFG_IDX_W   = 1;

  localparam logic [POS_W-1:0]  POS_MAX  = 8'd255;
  localparam logic [PEND_W-1:0] PEND_MAX = 7'd64;

  localparam logic [THR_W-1:0] THR_RESET = 16'd19661;
  localparam logic [WIN_W-1:0] WIN_RESET = 6'd16;

  localparam int MAX_WINDOW_DEF    = 63;
  localparam int MIN_BLOCK_DEF     = 32;
  localparam int HISTORY_DEPTH_DEF = 128;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic [DRAW_BITS-1:0]          random_draw;
    logic                          block_end;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          replaced;
    logic                          block_last;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_RD, ST_DECIDE, ST_SUM, ST_SUM_TAIL,
    ST_DIV_START, ST_DIV_WAIT, ST_EMIT, ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic rd_cur;
    logic latch_cur;
    logic sum_clr;
    logic rd_nb;
    logic div_start;
    logic emit;
    logic finish;
    logic flush;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pend_zero;
    logic go;
    logic rep_ok;
    logic blk_end;
    logic nb_last;
    logic div_done;
    logic out_free;
  } ctrl_sts_t;

endpackage
`default_nettype wire

// ===== sv/rssd_ram.sv =====
// rssd_ram: generic single write port, single read port RAM with registered read.
// Standalone; no package use.
`timescale 1ns / 1ps
`default_nettype none
module rssd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/rssd_div.sv =====
// rssd_div: signed by unsigned restoring divider, one quotient bit per cycle,
// truncates toward zero. Depends on rssd_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none
module rssd_div (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic signed [rssd_pkg::SUM_W-1:0] dividend,
  input  wire logic [rssd_pkg::DIV_W-1:0]        divisor,
  output      logic                              done,
  output      logic signed [rssd_pkg::SUM_W-1:0] quotient
);

  localparam int NW = rssd_pkg::SUM_W;
  localparam int DW = rssd_pkg::DIV_W;
  localparam int CW = $clog2(NW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] q_r, q_nxt;
  logic [DW-1:0] dvs_r, dvs_nxt;
  logic          neg_r, neg_nxt;
  logic [DW:0]   sh;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    sh       = {rem_r, q_r[NW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NW);
      rem_nxt  = '0;
      q_nxt    = dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
      dvs_nxt  = divisor;
      neg_nxt  = dividend[NW-1];
    end else if (busy_r) begin
      if (sh >= {1'b0, dvs_r}) begin
        rem_nxt = DW'(sh - {1'b0, dvs_r});
        q_nxt   = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = sh[DW-1:0];
        q_nxt   = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(q_r) : $signed(q_r);

endmodule
`default_nettype wire

// ===== sv/rssd_ctrl.sv =====
// rssd_ctrl: sequencer for accept, per-sample decide, neighbor sum, divide, emit, flush.
// Depends on rssd_pkg for state, command and status types.
`timescale 1ns / 1ps
`default_nettype none
module rssd_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire rssd_pkg::ctrl_sts_t  sts,
  output      rssd_pkg::ctrl_cmd_t  cmd
);

  rssd_pkg::state_t state_r, state_nxt;
  logic             flush_r, flush_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rssd_pkg::ST_IDLE;
      flush_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      flush_r <= flush_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    flush_nxt = flush_r;
    cmd       = '0;
    cmd.flush = flush_r;
    in_ready  = 1'b0;
    unique case (state_r)
      rssd_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) state_nxt = rssd_pkg::ST_CHECK;
      end
      rssd_pkg::ST_CHECK: begin
        priority if (sts.pend_zero) begin
          state_nxt = rssd_pkg::ST_FINISH;
        end else if (flush_r || sts.go) begin
          state_nxt = rssd_pkg::ST_RD;
        end else if (sts.blk_end) begin
          flush_nxt = 1'b1;
          state_nxt = rssd_pkg::ST_RD;
        end else begin
          state_nxt = rssd_pkg::ST_FINISH;
        end
      end
      rssd_pkg::ST_RD: begin
        cmd.rd_cur = 1'b1;
        state_nxt  = rssd_pkg::ST_DECIDE;
      end
      rssd_pkg::ST_DECIDE: begin
        cmd.latch_cur = 1'b1;
        cmd.sum_clr   = 1'b1;
        if (!flush_r && sts.rep_ok) state_nxt = rssd_pkg::ST_SUM;
        else state_nxt = rssd_pkg::ST_EMIT;
      end
      rssd_pkg::ST_SUM: begin
        cmd.rd_nb = 1'b1;
        if (sts.nb_last) state_nxt = rssd_pkg::ST_SUM_TAIL;
      end
      rssd_pkg::ST_SUM_TAIL: begin
        state_nxt = rssd_pkg::ST_DIV_START;
      end
      rssd_pkg::ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = rssd_pkg::ST_DIV_WAIT;
      end
      rssd_pkg::ST_DIV_WAIT: begin
        if (sts.div_done) state_nxt = rssd_pkg::ST_EMIT;
      end
      rssd_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = rssd_pkg::ST_CHECK;
        end
      end
      rssd_pkg::ST_FINISH: begin
        cmd.finish = 1'b1;
        flush_nxt  = 1'b0;
        state_nxt  = rssd_pkg::ST_IDLE;
      end
      default: state_nxt = rssd_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/rssd_dp.sv =====
// rssd_dp: history rings, block counters, neighbor accumulator, divider and output register.
// Depends on rssd_pkg, rssd_ram and rssd_div.
`timescale 1ns / 1ps
`default_nettype none
module rssd_dp #(
  parameter int MAX_WINDOW    = rssd_pkg::MAX_WINDOW_DEF,
  parameter int MIN_BLOCK     = rssd_pkg::MIN_BLOCK_DEF,
  parameter int HISTORY_DEPTH = rssd_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire rssd_pkg::in_t                   in_data,
  output      rssd_pkg::out_t                  out_data,
  output      logic                            out_valid,
  input  wire logic                            out_ready,
  input  wire logic                            cfg_valid,
  input  wire logic [rssd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rssd_pkg::THR_W-1:0]      cfg_data,
  input  wire rssd_pkg::ctrl_cmd_t             cmd,
  output      rssd_pkg::ctrl_sts_t             sts
);

  localparam int D    = HISTORY_DEPTH;
  localparam int AW   = $clog2(D);
  localparam int SB   = rssd_pkg::SAMPLE_BITS;
  localparam int WCAP = (MAX_WINDOW < (D - 1) / 2) ? MAX_WINDOW : (D - 1) / 2;

  logic [rssd_pkg::THR_W-1:0]  thr_r;
  logic [rssd_pkg::WIN_W-1:0]  win_r;
  logic [rssd_pkg::WIN_W-1:0]  w_r;
  logic [rssd_pkg::POS_W-1:0]  k_r;
  logic [rssd_pkg::PEND_W-1:0] pend_r;
  logic [AW-1:0]               wr_r, newest_r;
  logic                        end_r;
  logic [D-1:0]                vld_r;
  logic                        rd_vld_r;
  logic                        acc_en_r;
  logic [rssd_pkg::CNT_W-1:0]  cnt_r;
  logic signed [rssd_pkg::SUM_W-1:0] acc_r;
  logic signed [SB-1:0]        cur_r;
  logic                        rep_r;
  rssd_pkg::out_t              out_r;
  logic                        out_valid_r;

  logic [rssd_pkg::WIN_W-1:0]  w_eff;
  logic [rssd_pkg::AGE_W-1:0]  age;
  logic [rssd_pkg::POS_W-1:0]  idx;
  logic                        pass, rdy;
  logic [AW:0]                 s_tmp, nb_tmp;
  logic [AW-1:0]               s_addr, nb_addr, rd_addr, sw_addr;
  logic [rssd_pkg::CNT_W-1:0]  two_w, off;
  logic                        s_we;
  logic signed [SB-1:0]        s_wdata, s_rdata, s_rd;
  logic [rssd_pkg::DRAW_BITS-1:0] d_rdata, d_rd;
  logic                        out_free;
  logic                        div_done;
  logic signed [rssd_pkg::SUM_W-1:0] quot;

  assign w_eff = (win_r > rssd_pkg::WIN_W'(WCAP)) ? rssd_pkg::WIN_W'(WCAP) : win_r;

  // where the oldest pending sample sits and whether it can be settled now
  assign age  = rssd_pkg::AGE_W'(pend_r - 1'b1);
  assign idx  = ({2'b00, age} <= k_r) ? k_r - {2'b00, age} : '0;
  assign pass = (w_r == '0) || (idx < {2'b00, w_r});
  assign rdy  = (age >= w_r) && (({1'b0, k_r} + 9'd1) >= 9'(MIN_BLOCK));

  assign s_tmp  = (AW+1)'(newest_r) + (AW+1)'(D) - (AW+1)'(age);
  assign s_addr = (s_tmp >= (AW+1)'(D)) ? AW'(s_tmp - (AW+1)'(D)) : AW'(s_tmp);

  // neighbor walk: first the earlier W, then the later W
  assign two_w = {w_r, 1'b0};
  always_comb begin
    if (cnt_r < {1'b0, w_r}) begin
      off    = cnt_r + 1'b1;
      nb_tmp = (AW+1)'(s_addr) + (AW+1)'(D) - (AW+1)'(off);
    end else begin
      off    = cnt_r - {1'b0, w_r} + 1'b1;
      nb_tmp = (AW+1)'(s_addr) + (AW+1)'(off);
    end
  end
  assign nb_addr = (nb_tmp >= (AW+1)'(D)) ? AW'(nb_tmp - (AW+1)'(D)) : AW'(nb_tmp);
  assign rd_addr = cmd.rd_nb ? nb_addr : s_addr;

  assign s_we    = cmd.accept || (cmd.emit && rep_r);
  assign sw_addr = cmd.accept ? wr_r : s_addr;
  assign s_wdata = cmd.accept ? in_data.sample_in : cur_r;

  rssd_ram #(.WIDTH(SB), .DEPTH(D)) u_smp_ram (
    .clk  (clk),
    .we   (s_we),
    .waddr(sw_addr),
    .wdata(s_wdata),
    .raddr(rd_addr),
    .rdata(s_rdata)
  );

  rssd_ram #(.WIDTH(rssd_pkg::DRAW_BITS), .DEPTH(D)) u_drw_ram (
    .clk  (clk),
    .we   (cmd.accept),
    .waddr(wr_r),
    .wdata(in_data.random_draw),
    .raddr(rd_addr),
    .rdata(d_rdata)
  );

  // never-written entries read as zero
  assign s_rd = rd_vld_r ? s_rdata : '0;
  assign d_rd = rd_vld_r ? d_rdata : '0;

  rssd_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .dividend(acc_r),
    .divisor (two_w),
    .done    (div_done),
    .quotient(quot)
  );

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= rssd_pkg::THR_RESET;
      win_r       <= rssd_pkg::WIN_RESET;
      k_r         <= '0;
      pend_r      <= '0;
      wr_r        <= '0;
      vld_r       <= '0;
      acc_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          rssd_pkg::CFG_THRESHOLD: thr_r <= cfg_data;
          rssd_pkg::CFG_WINDOW:    win_r <= cfg_data[rssd_pkg::WIN_W-1:0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        vld_r[wr_r] <= 1'b1;
        wr_r        <= (wr_r == AW'(D - 1)) ? '0 : wr_r + 1'b1;
        if (pend_r < rssd_pkg::PEND_MAX) pend_r <= pend_r + 1'b1;
      end else if (cmd.emit) begin
        pend_r <= pend_r - 1'b1;
      end
      if (cmd.finish) begin
        if (end_r) k_r <= '0;
        else if (k_r != rssd_pkg::POS_MAX) k_r <= k_r + 1'b1;
      end
      acc_en_r <= cmd.rd_nb;
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
    if (cmd.accept) begin
      newest_r <= wr_r;
      end_r    <= in_data.block_end;
      w_r      <= w_eff;
    end
    rd_vld_r <= vld_r[rd_addr];
    if (cmd.sum_clr) begin
      acc_r <= '0;
      cnt_r <= '0;
    end else begin
      if (acc_en_r) acc_r <= acc_r + {{(rssd_pkg::SUM_W-SB){s_rd[SB-1]}}, s_rd};
      if (cmd.rd_nb) cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.latch_cur) begin
      cur_r <= s_rd;
      rep_r <= !cmd.flush && !pass && (d_rd < thr_r);
    end else if (div_done) begin
      cur_r <= quot[SB-1:0];
    end
    if (cmd.emit) begin
      out_r.sample_out <= cur_r;
      out_r.replaced   <= rep_r;
      out_r.block_last <= end_r && (age == '0);
    end
  end

  always_comb begin
    sts.pend_zero = (pend_r == '0);
    sts.go        = pass || rdy;
    sts.rep_ok    = !pass && (d_rd < thr_r);
    sts.blk_end   = end_r;
    sts.nb_last   = (cnt_r == two_w - 1'b1);
    sts.div_done  = div_done;
    sts.out_free  = out_free;
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= rssd_pkg::PEND_MAX) else $error("pending count over bound");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> out_free) else $error("result loaded over an untaken one");
  a_flush_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && end_r) |=> (pend_r == '0)) else $error("block end left samples pending");
  a_sum_rep: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_nb |-> (rep_r && (w_r != '0))) else $error("neighbor read without replacement");

endmodule
`default_nettype wire

// ===== sv/random_sample_smoothing_dropout.sv =====
// Path: a passed sample goes through CHECK, RD, DECIDE and EMIT into the output register;
//   a replaced one adds 2W neighbor reads, SUM_TAIL, DIV_START and the divider wait first.
// Input: in_ready is high only in ST_IDLE, so a new beat is taken only after the
//   sequencer has settled every pending sample it can, output stalls included; the single
//   read port of the history RAM and the bit-serial divider bound that work.
// Reset (rst_n, synchronous, active low) drops pending samples, restores the
//   registers, and marks all history invalid at once so it reads as zero.
`timescale 1ns / 1ps
`default_nettype none
module random_sample_smoothing_dropout #(
  parameter int MAX_WINDOW    = rssd_pkg::MAX_WINDOW_DEF,
  parameter int MIN_BLOCK     = rssd_pkg::MIN_BLOCK_DEF,
  parameter int HISTORY_DEPTH = rssd_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input beats: sample, draw, end-of-block mark
  input  wire logic                            in_valid,
  output      logic                            in_ready,
  input  wire rssd_pkg::in_t                   in_data,
  // result beats, held in an output register
  output      logic                            out_valid,
  input  wire logic                            out_ready,
  output      rssd_pkg::out_t                  out_data,
  // configuration writes, always taken
  input  wire logic                            cfg_valid,
  output      logic                            cfg_ready,
  input  wire logic [rssd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rssd_pkg::THR_W-1:0]      cfg_data
);

  rssd_pkg::ctrl_cmd_t cmd;
  rssd_pkg::ctrl_sts_t sts;

  assign cfg_ready = 1'b1;

  // sequencer: takes one beat, then settles every pending sample it can
  rssd_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // history rings, neighbor sum, divider and the output register
  rssd_dp #(
    .MAX_WINDOW   (MAX_WINDOW),
    .MIN_BLOCK    (MIN_BLOCK),
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .out_data (out_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule
`default_nettype wire

// ===== tb/tb_random_sample_smoothing_dropout.sv =====
// Self-checking testbench for random_sample_smoothing_dropout: directed blocks and random
// blocks, checked beat by beat against an in-bench predictor. Depends on rssd_pkg and the DUT.
`timescale 1ns / 1ps
module tb_random_sample_smoothing_dropout;

  localparam int RING      = 128;
  localparam int MIN_BLK   = 32;
  localparam int SETTLE    = 400;   // cycles for work on held samples to finish
  localparam int WD_LIMIT  = 40000; // cycles with no beat on any channel
  localparam int SB        = rssd_pkg::SAMPLE_BITS;
  localparam int DB        = rssd_pkg::DRAW_BITS;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  rssd_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rssd_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rssd_pkg::CFG_IDX_W-1:0] cfg_index = rssd_pkg::CFG_THRESHOLD;
  logic [rssd_pkg::THR_W-1:0] cfg_data = '0;

  always #6 clk = ~clk;

  random_sample_smoothing_dropout dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Smoothing predictor: its own ring of raw/processed samples and draws
  // ---------------------------------------------------------------------------
  int hist_smp [RING];
  int hist_drw [RING];
  int blk_pos;     // index of next sample in its block, saturates at 255
  int held_cnt;    // samples waiting for their fate
  int ring_ptr;
  int thr_reg;
  int win_reg;
  rssd_pkg::out_t smoothed_q[$];  // expected result beats, oldest first

  int snd_idle_pct;
  int rcv_stall_pct;
  int mismatches;
  int idle_cycles;

  function automatic void predict_smoothing(rssd_pkg::in_t x);
    int k, nw, w, age, s, idx, sum;
    bit pass, rdy, rep;
    rssd_pkg::out_t o;
    k  = blk_pos;
    nw = ring_ptr;
    w  = win_reg;  // 6-bit register never exceeds 63, the ring bound
    hist_smp[nw] = int'(x.sample_in);
    hist_drw[nw] = int'(x.random_draw);
    ring_ptr = (nw + 1) % RING;
    if (held_cnt < 64) held_cnt++;
    while (held_cnt > 0) begin
      age  = held_cnt - 1;
      s    = (nw + RING - age) % RING;
      idx  = (age <= k) ? k - age : 0;
      pass = (w == 0) || (idx < w);
      rdy  = (age >= w) && (k + 1 >= MIN_BLK);
      if (!pass && !rdy) break;
      rep = 1'b0;
      if (!pass && hist_drw[s] < thr_reg) begin
        sum = 0;
        for (int j = 1; j <= w; j++) begin
          sum += hist_smp[(s + RING - j) % RING];
          sum += hist_smp[(s + j) % RING];
        end
        hist_smp[s] = sum / (2 * w);  // signed int divide truncates toward zero
        rep = 1'b1;
      end
      o.sample_out = hist_smp[s][SB-1:0];
      o.replaced   = rep;
      o.block_last = x.block_end && (age == 0);
      smoothed_q.push_back(o);
      held_cnt--;
    end
    if (x.block_end) begin
      // flush the tail of the block unchanged
      while (held_cnt > 0) begin
        age = held_cnt - 1;
        s   = (nw + RING - age) % RING;
        o.sample_out = hist_smp[s][SB-1:0];
        o.replaced   = 1'b0;
        o.block_last = (age == 0);
        smoothed_q.push_back(o);
        held_cnt--;
      end
      blk_pos = 0;
    end else if (blk_pos < 255) begin
      blk_pos++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker, receiver stalls and watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rssd_pkg::out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (smoothed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: got %h", out_data);
      end else begin
        e = smoothed_q.pop_front();
        if (out_data.sample_out !== e.sample_out || out_data.replaced !== e.replaced ||
            out_data.block_last !== e.block_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp smp=%0d rep=%b last=%b, got smp=%0d rep=%b last=%b",
                     e.sample_out, e.replaced, e.block_last,
                     out_data.sample_out, out_data.replaced, out_data.block_last);
        end
      end
    end
    out_ready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Leaves in_valid high after the beat; stop_sending lowers it.
  task automatic send_sample(input int smp, input int drw, input bit last);
    rssd_pkg::in_t x;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    x.sample_in   = smp[SB-1:0];
    x.random_draw = drw[DB-1:0];
    x.block_end   = last;
    in_valid <= 1'b1;
    in_data  <= x;
    do @(posedge clk); while (!(in_valid && in_ready));
    predict_smoothing(x);
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait for every expected beat, then let the block finish held work
  task automatic drain();
    stop_sending();
    while (smoothed_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rssd_pkg::CFG_IDX_W-1:0] idx, input int val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[rssd_pkg::THR_W-1:0];
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    if (idx == rssd_pkg::CFG_WINDOW) win_reg = val & 63;
    else thr_reg = val & 16'hFFFF;
  endtask

  function automatic int rand_sample();
    case ($urandom_range(7))
      0: return -8388608;
      1: return 8388607;
      2: return int'($urandom_range(2000)) - 1000;
      default: return int'({{8{1'b0}}, 24'($urandom)}) - 8388608;
    endcase
  endfunction

  function automatic int rand_draw();
    case ($urandom_range(5))
      0: return 0;
      1: return 65535;
      default: return $urandom_range(65535);
    endcase
  endfunction

  task automatic send_block(input int len);
    for (int i = 0; i < len; i++)
      send_sample(rand_sample(), rand_draw(), i == len - 1);
  endtask

  task automatic set_idling(input int snd, input int rcv);
    snd_idle_pct  = snd;
    rcv_stall_pct = rcv;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // reset registers, full-scale values, a 34-sample block that can replace with W = 16
  task automatic test_defaults();
    for (int i = 0; i < MIN_BLK + 2; i++)
      send_sample((i % 2) ? 8388607 : -8388608, (i % 3) ? 0 : 65535, i == MIN_BLK + 1);
  endtask

  // blocks under 32 pass unchanged, including a single-sample block
  task automatic test_short_block();
    send_block(1);
    send_block(MIN_BLK - 1);
  endtask

  // window zero holds nothing back and replaces nothing
  task automatic test_window_zero();
    write_reg(rssd_pkg::CFG_WINDOW, 0);
    write_reg(rssd_pkg::CFG_THRESHOLD, 65535);
    send_block(MIN_BLK);
  endtask

  // register changes while samples of a block are still held; threshold zero first
  task automatic test_window_change_mid_block();
    write_reg(rssd_pkg::CFG_THRESHOLD, 0);
    write_reg(rssd_pkg::CFG_WINDOW, 4);
    for (int i = 0; i < 12; i++) send_sample(rand_sample(), rand_draw(), 1'b0);
    write_reg(rssd_pkg::CFG_THRESHOLD, 49152);
    write_reg(rssd_pkg::CFG_WINDOW, 9);
    for (int i = 0; i < 12; i++) send_sample(rand_sample(), rand_draw(), 1'b0);
    write_reg(rssd_pkg::CFG_WINDOW, 2);
    for (int i = 0; i < 12; i++) send_sample(rand_sample(), rand_draw(), i == 11);
  endtask

  // widest window, threshold 65535, one block past the 255 saturation point,
  // walked through every idling phase
  task automatic test_long_block();
    write_reg(rssd_pkg::CFG_WINDOW, 63);
    write_reg(rssd_pkg::CFG_THRESHOLD, 65535);
    for (int i = 0; i < 260; i++) begin
      case (i / 65)
        0: set_idling(0, 0);
        1: set_idling(66, 0);
        2: set_idling(0, 66);
        default: set_idling(11, 11);
      endcase
      send_sample(rand_sample(), rand_draw(), i == 259);
    end
  endtask

  initial begin
    blk_pos = 0; held_cnt = 0; ring_ptr = 0;
    thr_reg = rssd_pkg::THR_RESET; win_reg = rssd_pkg::WIN_RESET;
    for (int j = 0; j < RING; j++) begin
      hist_smp[j] = 0;
      hist_drw[j] = 0;
    end
    mismatches = 0;
    idle_cycles = 0;
    set_idling(0, 0);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_defaults();
    set_idling(66, 66);
    test_short_block();
    set_idling(66, 0);
    test_window_zero();
    set_idling(0, 66);
    test_window_change_mid_block();
    test_long_block();

    drain();
    if (mismatches == 0 && smoothed_q.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
